>>> design/ftba_pkg.sv
// Shared constants, codes and control types for the file table block allocator.
package ftba_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int NUM_BLOCKS  = 256;
  localparam int RSV_SLOTS   = 2;
  localparam int RSV_BLOCKS  = 2;

  localparam int OPCODE_W    = 2;
  localparam int FILE_ID_W   = 16;
  localparam int STATUS_W    = 3;
  localparam int SLOT_FLD_W  = 4;
  localparam int BLOCK_FLD_W = 8;

  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int BUSY_W      = (NUM_BLOCKS < 16) ? NUM_BLOCKS : 16;
  localparam int BIT_W       = $clog2(BUSY_W);
  localparam int NUM_CHUNKS  = (NUM_BLOCKS + BUSY_W - 1) / BUSY_W;
  localparam int CHUNK_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_NO_BLOCK  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_next;
    logic    do_create;
    logic    do_delete;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    hit;
    logic    free_ok;
    logic    chunk_free;
    logic    last_chunk;
    logic    out_free;
  } sts_t;

  // Reset image of one bitmap word: reserved blocks and padding past the end are busy.
  function automatic logic [BUSY_W-1:0] busy_init(input int c);
    logic [BUSY_W-1:0] w;
    w = '0;
    for (int j = 0; j < BUSY_W; j++) begin
      w[j] = ((c * BUSY_W + j) < RSV_BLOCKS) || ((c * BUSY_W + j) >= NUM_BLOCKS);
    end
    return w;
  endfunction

endpackage

>>> design/ftba_dp.sv
// Datapath: slot table, block bitmap, match and free search, result and output registers.
module ftba_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ftba_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [ftba_pkg::FILE_ID_W-1:0]   in_file_id,
  input  ftba_pkg::cmd_t                   cmd,
  output ftba_pkg::sts_t                   sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [ftba_pkg::STATUS_W-1:0]    out_status,
  output logic [ftba_pkg::SLOT_FLD_W-1:0]  out_slot,
  output logic [ftba_pkg::BLOCK_FLD_W-1:0] out_block
);
  import ftba_pkg::*;

  logic [OPCODE_W-1:0]  op;
  logic [FILE_ID_W-1:0] fid;

  logic [NUM_SLOTS-1:0] slot_used;
  logic [FILE_ID_W-1:0] slot_file  [NUM_SLOTS];
  logic [BLK_W-1:0]     slot_block [NUM_SLOTS];
  logic [BUSY_W-1:0]    busy       [NUM_CHUNKS];

  logic [SLOT_W-1:0]    free_slot;
  logic [CHUNK_W-1:0]   scan_cnt;

  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [BLK_W-1:0]     res_blk;

  logic                 hit;
  logic [SLOT_W-1:0]    hit_idx;
  logic                 free_ok;
  logic [SLOT_W-1:0]    free_idx;
  logic [BUSY_W-1:0]    chunk;
  logic                 chunk_free;
  logic [BIT_W-1:0]     bit_idx;
  logic [BLK_W-1:0]     new_blk;
  logic [BLK_W-1:0]     hit_blk;
  logic [CHUNK_W-1:0]   del_chunk;
  logic [BIT_W-1:0]     del_bit;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= RSV_SLOTS; i--) begin
      if (slot_used[i] && (slot_file[i] == fid)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_ok  = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    chunk      = busy[scan_cnt];
    chunk_free = ~&chunk;
    bit_idx    = '0;
    for (int j = BUSY_W - 1; j >= 0; j--) begin
      if (!chunk[j]) begin
        bit_idx = BIT_W'(j);
      end
    end
  end

  assign new_blk   = BLK_W'({scan_cnt, bit_idx});
  assign hit_blk   = slot_block[hit_idx];
  assign del_chunk = CHUNK_W'(hit_blk >> BIT_W);
  assign del_bit   = hit_blk[BIT_W-1:0];

  assign sts.op         = opcode_t'(op);
  assign sts.hit        = hit;
  assign sts.free_ok    = free_ok;
  assign sts.chunk_free = chunk_free;
  assign sts.last_chunk = (scan_cnt == CHUNK_W'(NUM_CHUNKS - 1));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_opcode;
      fid <= in_file_id;
    end
    if (cmd.scan_clr) begin
      free_slot <= free_idx;
    end
    if (cmd.do_create) begin
      slot_file[free_slot]  <= fid;
      slot_block[free_slot] <= new_blk;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      if (cmd.res_code != ST_OK) begin
        res_slot <= '0;
        res_blk  <= '0;
      end else if (cmd.do_create) begin
        res_slot <= free_slot;
        res_blk  <= new_blk;
      end else begin
        res_slot <= hit_idx;
        res_blk  <= hit_blk;
      end
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_slot   <= SLOT_FLD_W'(res_slot);
      out_block  <= BLOCK_FLD_W'(res_blk);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= {{(NUM_SLOTS - RSV_SLOTS){1'b0}}, {RSV_SLOTS{1'b1}}};
      for (int c = 0; c < NUM_CHUNKS; c++) begin
        busy[c] <= busy_init(c);
      end
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        scan_cnt <= '0;
      end else if (cmd.scan_next) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmd.do_create) begin
        slot_used[free_slot]    <= 1'b1;
        busy[scan_cnt][bit_idx] <= 1'b1;
      end
      if (cmd.do_delete) begin
        slot_used[hit_idx]      <= 1'b0;
        busy[del_chunk][del_bit] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/ftba_ctrl.sv
// Controller: command sequencing state machine.
module ftba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ftba_pkg::sts_t sts,
  output ftba_pkg::cmd_t cmd
);
  import ftba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        state_next = S_DONE;
        cmd.res_set = 1'b1;
        unique case (sts.op)
          OP_LOOKUP: begin
            cmd.res_code = sts.hit ? ST_OK : ST_NOT_FOUND;
          end
          OP_DELETE: begin
            cmd.res_code  = sts.hit ? ST_OK : ST_NOT_FOUND;
            cmd.do_delete = sts.hit;
          end
          OP_CREATE: begin
            priority if (sts.hit) begin
              cmd.res_code = ST_EXISTS;
            end else if (!sts.free_ok) begin
              cmd.res_code = ST_NO_SLOT;
            end else begin
              cmd.res_set  = 1'b0;
              cmd.scan_clr = 1'b1;
              state_next   = S_SCAN;
            end
          end
          default: begin
            cmd.res_code = ST_NOT_FOUND;
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts.chunk_free) begin
          cmd.do_create = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_code  = ST_OK;
          state_next    = S_DONE;
        end else if (sts.last_chunk) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NO_BLOCK;
          state_next   = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/file_table_block_allocator_unit.sv
// File table with free-block bitmap: top level.
// One command is in work at a time. A lookup, a delete, or a create that fails on an
// existing id or a full table goes from the input register through the match state and the
// result register to the output register before the next command is taken. A create that
// searches for a block reads one 16-bit bitmap word per cycle in the scan state, up to
// NUM_BLOCKS/16 words before its result is registered,
// also when no block is free. The result waits in an output register, and a new command
// is taken while it waits; a second finished result behind an unread one holds the input.
module file_table_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // file_id
  input  logic [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // slot_index[3:0], block_index[11:4], zero pad
  output logic [2:0]  m_axis_tuser    // status
);
  import ftba_pkg::*;

  cmd_t                   cmd;
  sts_t                   sts;
  logic [SLOT_FLD_W-1:0]  out_slot;
  logic [BLOCK_FLD_W-1:0] out_block;

  ftba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_opcode  (s_axis_tuser),
    .in_file_id (s_axis_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_slot   (out_slot),
    .out_block  (out_block)
  );

  assign m_axis_tdata = {4'b0000, out_block, out_slot};

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in work");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= ST_NO_BLOCK)
    else $error("result status out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("failed command returned nonzero indices");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the file table block allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;
  import ftba_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int NUM_RANDOM = 1050;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int PAUSE_AT = 700;
  localparam int DRAIN_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    status_t    status;
    logic [3:0] slot;
    logic [7:0] block;
  } file_result_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [15:0]  id;
    logic         fixed;
    file_result_t want;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic [15:0] s_id = '0;
  logic [1:0]  s_op = '0;
  logic        m_ready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;

  file_table_block_allocator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_id),
    .s_axis_tuser  (s_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow file table
  logic         tbl_used [NUM_SLOTS];
  logic [15:0]  tbl_file [NUM_SLOTS];
  logic [7:0]   tbl_block [NUM_SLOTS];
  logic         blk_busy [NUM_BLOCKS];

  file_result_t pending_results[$];
  cmd_row_t     dir_rows[$];
  logic [15:0]  id_pool [16];
  int           n_by_status [5];
  int           n_sent = 0;
  int           n_results = 0;
  int           n_errors = 0;
  bit           hold_done = 1'b0;
  file_result_t rx_got, rx_want;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int find_file(input logic [15:0] id);
    for (int i = RSV_SLOTS; i < NUM_SLOTS; i++) begin
      if (tbl_used[i] && tbl_file[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic file_result_t apply_file_cmd(input logic [1:0] op, input logic [15:0] id);
    file_result_t r;
    int s;
    int b;
    r = '{ST_NOT_FOUND, 4'd0, 8'd0};
    s = find_file(id);
    case (op)
      OP_LOOKUP: begin
        if (s >= 0) r = '{ST_OK, s[3:0], tbl_block[s]};
      end
      OP_CREATE: begin
        if (s >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          s = -1;
          b = -1;
          for (int i = 0; i < NUM_SLOTS; i++) if (s < 0 && !tbl_used[i]) s = i;
          for (int i = 0; i < NUM_BLOCKS; i++) if (b < 0 && !blk_busy[i]) b = i;
          if (s < 0) begin
            r.status = ST_NO_SLOT;
          end else if (b < 0) begin
            r.status = ST_NO_BLOCK;
          end else begin
            tbl_used[s] = 1'b1;
            tbl_file[s] = id;
            tbl_block[s] = b[7:0];
            blk_busy[b] = 1'b1;
            r = '{ST_OK, s[3:0], b[7:0]};
          end
        end
      end
      OP_DELETE: begin
        if (s >= 0) begin
          tbl_used[s] = 1'b0;
          blk_busy[tbl_block[s]] = 1'b0;
          r = '{ST_OK, s[3:0], tbl_block[s]};
        end
      end
      default: ;
    endcase
    n_by_status[int'(r.status)]++;
    return r;
  endfunction

  // Offer one command and hold it until transfer; the expectation is queued at transfer.
  task automatic send_cmd(input logic [1:0] op, input logic [15:0] id, input logic fixed,
                          input file_result_t want);
    file_result_t r;
    s_valid <= 1'b1;
    s_op <= op;
    s_id <= id;
    do @(posedge clk); while (!s_axis_tready);
    r = apply_file_cmd(op, id);
    pending_results.push_back(fixed ? want : r);
    n_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      s_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Receiver: changing stall patterns plus one long hold-off.
  initial begin
    int mode;
    int left;
    int phase;
    mode = 0;
    left = 100;
    phase = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && n_sent >= HOLD_AT) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(64, 256);
        end
        left--;
        phase++;
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= 1'($urandom_range(0, 1));
          2: m_ready <= (phase % 4 == 0);
          default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_ready) begin
      rx_got = '{status_t'(m_axis_tuser), m_axis_tdata[3:0], m_axis_tdata[11:4]};
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: status %0d slot %0d block %0d",
                   rx_got.status, rx_got.slot, rx_got.block);
      end else begin
        rx_want = pending_results.pop_front();
        if (rx_got.status !== rx_want.status || rx_got.slot !== rx_want.slot ||
            rx_got.block !== rx_want.block) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch at result %0d: expected status %0d slot %0d block %0d, got %0d %0d %0d",
                     n_results, rx_want.status, rx_want.slot, rx_want.block,
                     rx_got.status, rx_got.slot, rx_got.block);
        end
      end
    end
  end

  initial begin
    logic [1:0]  op;
    logic [15:0] id;
    int          burst;
    int          live;
    int          r;
    int          k;
    int          drain;
    file_result_t none;

    none = '{ST_OK, 4'd0, 8'd0};
    foreach (n_by_status[i]) n_by_status[i] = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_used[i] = (i < RSV_SLOTS);
      tbl_file[i] = '0;
      tbl_block[i] = '0;
    end
    for (int i = 0; i < NUM_BLOCKS; i++) blk_busy[i] = (i < RSV_BLOCKS);
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);

    // reserved slots never match; extremes of the id; then fill the table
    dir_rows.push_back('{OP_LOOKUP,  16'h0000, 1'b1, '{ST_NOT_FOUND, 4'd0, 8'd0}});
    dir_rows.push_back('{OP_DELETE,  16'h0000, 1'b1, '{ST_NOT_FOUND, 4'd0, 8'd0}});
    dir_rows.push_back('{OP_CREATE,  16'h0000, 1'b1, '{ST_OK,        4'd2, 8'd2}});
    dir_rows.push_back('{OP_CREATE,  16'hFFFF, 1'b1, '{ST_OK,        4'd3, 8'd3}});
    dir_rows.push_back('{OP_CREATE,  16'hFFFF, 1'b1, '{ST_EXISTS,    4'd0, 8'd0}});
    dir_rows.push_back('{OP_LOOKUP,  16'hFFFF, 1'b1, '{ST_OK,        4'd3, 8'd3}});
    dir_rows.push_back('{OP_UNKNOWN, 16'hFFFF, 1'b1, '{ST_NOT_FOUND, 4'd0, 8'd0}});
    dir_rows.push_back('{OP_DELETE,  16'h0000, 1'b1, '{ST_OK,        4'd2, 8'd2}});
    dir_rows.push_back('{OP_LOOKUP,  16'h0000, 1'b1, '{ST_NOT_FOUND, 4'd0, 8'd0}});
    dir_rows.push_back('{OP_CREATE,  16'h8001, 1'b1, '{ST_OK,        4'd2, 8'd2}});
    for (int i = 0; i < NUM_SLOTS - 4; i++)
      dir_rows.push_back('{OP_CREATE, 16'h1000 + i[15:0], 1'b0, none});
    dir_rows.push_back('{OP_CREATE,  16'h5555, 1'b1, '{ST_NO_SLOT,   4'd0, 8'd0}});
    dir_rows.push_back('{OP_CREATE,  16'hFFFF, 1'b1, '{ST_EXISTS,    4'd0, 8'd0}});
    dir_rows.push_back('{OP_DELETE,  16'hFFFF, 1'b1, '{ST_OK,        4'd3, 8'd3}});

    do @(posedge clk); while (rst);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].op, dir_rows[i].id, dir_rows[i].fixed, dir_rows[i].want);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
    end

    burst = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == PAUSE_AT) begin
        s_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        burst = $urandom_range(1, 24);
      end else if (burst == 0) begin
        idle_cycles($urandom_range(0, 8));
        burst = $urandom_range(1, 24);
      end
      burst--;

      live = 0;
      for (int i = RSV_SLOTS; i < NUM_SLOTS; i++) live += tbl_used[i];
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_UNKNOWN;
      else if (r < ((live >= 12) ? 34 : 49)) op = OP_CREATE;
      else if (r < ((live >= 12) ? 64 : 74)) op = OP_DELETE;
      else op = OP_LOOKUP;

      r = $urandom_range(0, 99);
      if (r < 50 && live > 0) begin
        do k = $urandom_range(RSV_SLOTS, NUM_SLOTS - 1); while (!tbl_used[k]);
        id = tbl_file[k];
      end else if (r < 85) begin
        id = id_pool[$urandom_range(0, 15)];
      end else begin
        id = 16'($urandom);
      end
      send_cmd(op, id, 1'b0, none);
    end
    s_valid <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_errors += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end

    $display("Run: %0d commands, %0d results, long output hold-off and full drain pause done",
             n_sent, n_results);
    $display("Outcomes: ok %0d, exists %0d, not found %0d, no slot %0d, no block %0d",
             n_by_status[0], n_by_status[1], n_by_status[2], n_by_status[3], n_by_status[4]);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
design/ftba_pkg.sv
design/ftba_dp.sv
design/ftba_ctrl.sv
design/file_table_block_allocator_unit.sv
tb/tb_top.sv
